// File: design/raw10_packed_pixel_unpack_unit_assert.svh
// ----------------------------------------------------------------------------
// RAW10 unpack unit assertion macros
// Shared property forms for the checker of the unpack unit.
// ----------------------------------------------------------------------------
`ifndef RAW10_PACKED_PIXEL_UNPACK_UNIT_ASSERT_SVH
`define RAW10_PACKED_PIXEL_UNPACK_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPPU_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("rppu assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define RPPU_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("rppu assertion failed in the next cycle");

`endif

// File: design/rppu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAW10 unpack package
// Types and fixed constants shared by the modules of the unpack unit.
// ----------------------------------------------------------------------------
package rppu_pkg;

   localparam int MAX_WIDTH      = 8192;
   localparam int MAX_HEIGHT     = 8192;
   localparam int CFG_W          = 14;
   localparam int QUEUE_DEPTH    = 4;
   localparam int LO_BYTES       = 4;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ROW_STRIDE   = 2'd2;

   typedef struct packed {
      logic [3:0][7:0] lo_bytes;
      logic [7:0]      hi_byte;
      logic [1:0]      last_index;
      logic            row_last;
      logic            frame_last;
      logic            cfg_error;
   } group_type;

endpackage

// File: design/rppu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAW10 unpack front end
// Holds the registers, tracks group and row position, gathers the bytes of a
// group and hands one entry per completed group or per rejected beat on.
// ----------------------------------------------------------------------------
module rppu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [13:0]          csr_wdata,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   output logic                 push,
   output rppu_pkg::group_type  entry
);

   logic [13:0]     width_ff, width_in;
   logic [13:0]     height_ff, height_in;
   logic [13:0]     stride_ff, stride_in;
   logic [3:0][7:0] store_ff, store_in;
   logic [2:0]      gpos_ff, gpos_in;
   logic [13:0]     pos_ff, pos_in;
   logic [12:0]     row_ff, row_in;

   logic [12:0]     groups;
   logic [14:0]     packed_size;
   logic [14:0]     stride_eff;
   logic [14:0]     pos_next;
   logic [13:0]     row_next;
   logic            cfg_bad;
   logic            row_last;
   logic            frame_last;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      stride_in = stride_ff;
      if (csr_wr_en) begin
         priority if (csr_index == rppu_pkg::CSR_FRAME_WIDTH) begin
            width_in = csr_wdata;
         end else if (csr_index == rppu_pkg::CSR_FRAME_HEIGHT) begin
            height_in = csr_wdata;
         end else if (csr_index == rppu_pkg::CSR_ROW_STRIDE) begin
            stride_in = csr_wdata;
         end
      end
   end

   always_comb begin
      groups      = 13'((15'(width_ff) + 15'd3) >> 2);
      packed_size = {groups, 2'b00} + 15'(groups);
      stride_eff  = (stride_ff == '0) ? packed_size : 15'(stride_ff);
      cfg_bad     = (width_ff == '0) || (height_ff == '0)
                    || (32'(width_ff) > 32'(rppu_pkg::MAX_WIDTH))
                    || (32'(height_ff) > 32'(rppu_pkg::MAX_HEIGHT))
                    || (stride_eff < packed_size);
      pos_next    = 15'(pos_ff) + 15'd1;
      row_next    = 14'(row_ff) + 14'd1;
      row_last    = pos_next >= packed_size;
      frame_last  = row_last && (row_next >= height_ff);

      store_in = store_ff;
      gpos_in  = gpos_ff;
      pos_in   = pos_ff;
      row_in   = row_ff;
      push     = 1'b0;
      entry    = '0;

      if (accept) begin
         if (cfg_bad) begin
            push            = 1'b1;
            entry.cfg_error = 1'b1;
         end else begin
            if (15'(pos_ff) < packed_size) begin
               if (gpos_ff < 3'(rppu_pkg::LO_BYTES)) begin
                  store_in[gpos_ff[1:0]] = in_byte;
                  gpos_in                = gpos_ff + 3'd1;
               end else begin
                  push             = 1'b1;
                  entry.lo_bytes   = store_ff;
                  entry.hi_byte    = in_byte;
                  entry.row_last   = row_last;
                  entry.frame_last = frame_last;
                  entry.last_index = (row_last && (width_ff[1:0] != 2'd0))
                                     ? width_ff[1:0] - 2'd1 : 2'd3;
                  gpos_in          = '0;
               end
            end
            if (pos_next >= stride_eff) begin
               pos_in  = '0;
               gpos_in = '0;
               row_in  = (row_next >= height_ff) ? '0 : row_next[12:0];
            end else begin
               pos_in = pos_next[13:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         stride_ff <= '0;
         store_ff  <= '0;
         gpos_ff   <= '0;
         pos_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         stride_ff <= stride_in;
         store_ff  <= store_in;
         gpos_ff   <= gpos_in;
         pos_ff    <= pos_in;
         row_ff    <= row_in;
      end
   end

endmodule

// File: design/rppu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAW10 unpack group queue
// Small first-in first-out store of group entries between front and back.
// ----------------------------------------------------------------------------
module rppu_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rppu_pkg::group_type  push_entry,
   input  logic                 pop,
   output rppu_pkg::group_type  head,
   output logic                 empty,
   output logic                 full
);

   localparam int Depth  = rppu_pkg::QUEUE_DEPTH;
   localparam int PtrW   = $clog2(Depth);
   localparam int CountW = $clog2(Depth + 1);

   rppu_pkg::group_type slots_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CountW'(Depth));
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/rppu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAW10 unpack back end
// Expands each queued group into its pixels, one per cycle while the output
// register that presents the oldest result is free to take the next one.
// ----------------------------------------------------------------------------
module rppu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  rppu_pkg::group_type  head,
   input  logic                 head_empty,
   output logic                 head_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [9:0]           rsp_pixel,
   output logic                 rsp_row_end,
   output logic                 rsp_frame_end,
   output logic                 rsp_config_error,
   output logic                 rsp_last
);

   logic [1:0] index_ff, index_in;
   logic       valid_ff, valid_in;
   logic [9:0] pixel_ff, pixel_in;
   logic       row_end_ff, row_end_in;
   logic       frame_end_ff, frame_end_in;
   logic       error_ff, error_in;
   logic       last_ff, last_in;
   logic       slot_free;
   logic       fire;
   logic       fin;

   always_comb begin
      slot_free    = !valid_ff || rsp_pop;
      fire         = !head_empty && slot_free;
      fin          = (index_ff == head.last_index);
      head_pop     = fire && fin;
      valid_in     = fire || (valid_ff && !rsp_pop);
      index_in     = index_ff;
      pixel_in     = pixel_ff;
      row_end_in   = row_end_ff;
      frame_end_in = frame_end_ff;
      error_in     = error_ff;
      last_in      = last_ff;
      if (fire) begin
         index_in     = fin ? 2'd0 : index_ff + 2'd1;
         pixel_in     = {head.hi_byte[{index_ff, 1'b1} -: 2], head.lo_bytes[index_ff]};
         row_end_in   = head.row_last && fin;
         frame_end_in = head.frame_last && fin;
         error_in     = head.cfg_error;
         last_in      = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff     <= pixel_in;
      row_end_ff   <= row_end_in;
      frame_end_ff <= frame_end_in;
      error_ff     <= error_in;
      last_ff      <= last_in;
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_pixel        = pixel_ff;
   assign rsp_row_end      = row_end_ff;
   assign rsp_frame_end    = frame_end_ff;
   assign rsp_config_error = error_ff;
   assign rsp_last         = last_ff;

endmodule

// File: design/raw10_packed_pixel_unpack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAW10 packed pixel unpack unit
// Unpacks a RAW10 byte stream into ten-bit pixels with row and frame
// markers, dropping row padding and flagging invalid frame geometry.
// ----------------------------------------------------------------------------
// One byte beat is taken per cycle whenever the four-entry group queue has
// room. Each fifth byte of a group yields up to four pixel beats, produced one
// per cycle by the back end while its output register is free, so the stream
// runs at full byte rate as long as results are taken. With an invalid
// geometry every byte yields a single error beat, also at one per cycle. The
// first pixel of a group reaches the result ports, when the queue holds nothing
// older and the output register is free, through the queue slot, written when
// the byte that completes the group is taken, and then the output register,
// loaded from the queue head.
// ----------------------------------------------------------------------------
module raw10_packed_pixel_unpack_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [9:0]  rsp_pixel,
   output logic        rsp_row_end,
   output logic        rsp_frame_end,
   output logic        rsp_config_error,
   output logic        rsp_last
);

   rppu_pkg::group_type push_entry;
   rppu_pkg::group_type head;
   logic                push;
   logic                head_empty;
   logic                head_pop;
   logic                accept;

   assign accept = req_push && !req_full;

   rppu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .push      (push),
      .entry     (push_entry)
   );

   rppu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (head_pop),
      .head       (head),
      .empty      (head_empty),
      .full       (req_full)
   );

   rppu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_empty       (head_empty),
      .head_pop         (head_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel        (rsp_pixel),
      .rsp_row_end      (rsp_row_end),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_config_error (rsp_config_error),
      .rsp_last         (rsp_last)
   );

endmodule

// File: design/rppu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAW10 unpack port checker
// Watches the result ports of the unpack unit for consistent beats and markers.
// ----------------------------------------------------------------------------
`include "raw10_packed_pixel_unpack_unit_assert.svh"

module rppu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [9:0] rsp_pixel,
   input logic       rsp_row_end,
   input logic       rsp_frame_end,
   input logic       rsp_config_error,
   input logic       rsp_last
);

   `RPPU_ASSERT_SAME(a_error_beat_clean, clock, reset, !rsp_empty && rsp_config_error,
      rsp_pixel == 10'd0 && rsp_last && !rsp_row_end && !rsp_frame_end)
   `RPPU_ASSERT_SAME(a_row_end_is_last, clock, reset, !rsp_empty && rsp_row_end, rsp_last)
   `RPPU_ASSERT_SAME(a_frame_end_on_row_end, clock, reset, !rsp_empty && rsp_frame_end,
      rsp_row_end)
   `RPPU_ASSERT_NEXT(a_stalled_beat_holds, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_pixel) && $stable(rsp_last))

endmodule

bind raw10_packed_pixel_unpack_unit rppu_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_pixel        (rsp_pixel),
   .rsp_row_end      (rsp_row_end),
   .rsp_frame_end    (rsp_frame_end),
   .rsp_config_error (rsp_config_error),
   .rsp_last         (rsp_last)
);
